FILE: hw/rtl/mi_pkg.sv
// Shared constants for the modular inverse pipeline.
package mi_pkg;

  localparam int unsigned WIDTH = 30;
  localparam logic [WIDTH-1:0] MODULUS = 30'd1000000007;
  localparam logic [WIDTH-1:0] EXPONENT = 30'd1000000005;
  // Barrett constant: floor(2^60 / MODULUS), fits in 31 bits.
  localparam logic [30:0] MU = 31'd1152921496;
  localparam int unsigned STEPS = 30;
  localparam int unsigned MUL_LAT = 5;
  // One input stage plus one modular multiply per exponent bit.
  localparam int unsigned LATENCY = 1 + STEPS * MUL_LAT;

  typedef logic [WIDTH-1:0] residue_t;

endpackage

FILE: hw/rtl/modular_inverse_fermat.sv
// Top level of the modular inverse engine for the prime 1000000007.
//
// Each transfer presents one 30-bit residue on value with start high; the
// engine returns value^(1000000005) mod 1000000007 on inverse, which is the
// multiplicative inverse for a nonzero residue and zero for zero. Inputs at
// or above the prime are first reduced by one subtraction. The engine is a
// fully pipelined square-and-multiply: one input register, then thirty
// steps of five stages each (one per exponent bit, every step running a
// pipelined Barrett multiplier); each result leaves the last step together
// with a one-cycle done strobe. A new item may be transferred in every
// cycle; busy is always low. The receiver cannot stall the engine, so it
// must take each result in the cycle that done is high.
module modular_inverse_fermat (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mi_pkg::residue_t value,
  output logic             done,
  output mi_pkg::residue_t inverse
);
  import mi_pkg::*;

  // Valid bits travel alongside the data through every stage.
  logic [LATENCY-1:0] vld;
  residue_t sq  [STEPS];
  residue_t res [STEPS+1];
  residue_t last_sq;

  // Input stage: fold residues at or above the prime back into range.
  always_ff @(posedge clk) begin
    sq[0]  <= (value >= MODULUS) ? value - MODULUS : value;
    res[0] <= residue_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start};
    end
  end

  genvar i;
  generate
    for (i = 0; i < STEPS - 1; i++) begin : g_step
      mi_step u_step (
        .clk     (clk),
        .bit_set (EXPONENT[i]),
        .sq_in   (sq[i]),
        .res_in  (res[i]),
        .sq_out  (sq[i+1]),
        .res_out (res[i+1])
      );
    end
  endgenerate

  // The top exponent bit is set and needs no further square.
  assign last_sq = sq[STEPS-1];

  mi_modmul u_last (
    .clk (clk),
    .a   (res[STEPS-1]),
    .b   (last_sq),
    .p   (res[STEPS])
  );

  assign busy    = 1'b0;
  assign done    = vld[LATENCY-1];
  assign inverse = res[STEPS];

  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##151 done)
    else $error("result strobe missing after fixed latency");

  a_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (inverse < MODULUS))
    else $error("result not reduced below the prime");

  a_reset_quiet : assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

FILE: hw/rtl/mi_modmul.sv
// Five-stage pipelined modular multiplier with Barrett reduction.
module mi_modmul (
  input  logic            clk,
  input  mi_pkg::residue_t a,
  input  mi_pkg::residue_t b,
  output mi_pkg::residue_t p
);
  import mi_pkg::*;

  logic [59:0] prod;
  logic [30:0] quot;
  logic [31:0] plo1;
  logic [31:0] plo2;
  logic [31:0] qm;
  logic [31:0] rem;
  logic [61:0] qest;
  logic [61:0] qmfull;
  logic [32:0] sub1;
  logic [32:0] sub2;

  assign qest   = 62'(prod[59:29]) * 62'(MU);
  assign qmfull = 62'(quot) * 62'(MODULUS);
  assign sub1   = {1'b0, rem} - 33'(MODULUS);
  assign sub2   = {1'b0, rem} - (33'(MODULUS) << 1);

  always_ff @(posedge clk) begin
    prod <= 60'(a) * 60'(b);
    quot <= qest[61:31];
    plo1 <= prod[31:0];
    qm   <= qmfull[31:0];
    plo2 <= plo1;
    rem  <= plo2 - qm;
    // The Barrett estimate is at most two short of the true quotient.
    if (!sub2[32]) begin
      p <= sub2[WIDTH-1:0];
    end else if (!sub1[32]) begin
      p <= sub1[WIDTH-1:0];
    end else begin
      p <= rem[WIDTH-1:0];
    end
  end

endmodule

FILE: hw/rtl/mi_step.sv
// One square-and-multiply step: squares the running power and folds it in on a set bit.
module mi_step (
  input  logic            clk,
  input  logic            bit_set,
  input  mi_pkg::residue_t sq_in,
  input  mi_pkg::residue_t res_in,
  output mi_pkg::residue_t sq_out,
  output mi_pkg::residue_t res_out
);
  import mi_pkg::*;

  residue_t factor;

  assign factor = bit_set ? sq_in : residue_t'(1);

  mi_modmul u_sq (
    .clk (clk),
    .a   (sq_in),
    .b   (sq_in),
    .p   (sq_out)
  );

  mi_modmul u_res (
    .clk (clk),
    .a   (res_in),
    .b   (factor),
    .p   (res_out)
  );

endmodule
